// ===== rtl/clipped_line_pixel_walker_assert.svh =====
// Assertion macros for the line walker RTL.
`ifndef CLIPPED_LINE_PIXEL_WALKER_ASSERT_SVH
`define CLIPPED_LINE_PIXEL_WALKER_ASSERT_SVH

// Clocked check, off while reset is held.
`define CLPW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check, live during reset too.
`define CLPW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/clpw_pkg.sv =====
// Shared types and constants for the clipped line pixel walker.
package clpw_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int IO_COORD_W     = 16;
  localparam int OFFSET_W       = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  localparam int LEFT_W   = 12;
  localparam int WIDTH_W  = 13;
  localparam int HEIGHT_W = 13;
  localparam int BPP_W    = 6;
  localparam int STRIDE_W = 16;

  // Inside the window a coordinate is below an extent register, so it fits this width.
  localparam int WIN_COORD_W = 13;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_DEPTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE   = 3'd4;

  localparam logic [LEFT_W-1:0]   RST_WINDOW_LEFT   = 12'd0;
  localparam logic [WIDTH_W-1:0]  RST_WINDOW_WIDTH  = 13'd1024;
  localparam logic [HEIGHT_W-1:0] RST_WINDOW_HEIGHT = 13'd768;
  localparam logic [BPP_W-1:0]    RST_PIXEL_DEPTH   = 6'd32;
  localparam logic [STRIDE_W-1:0] RST_LINE_STRIDE   = 16'd4096;

  typedef struct packed {
    logic [LEFT_W-1:0]   window_left;
    logic [WIDTH_W-1:0]  window_width;
    logic [HEIGHT_W-1:0] window_height;
    logic [BPP_W-1:0]    pixel_depth;
    logic [STRIDE_W-1:0] line_stride;
  } clpw_cfg_t;

endpackage

// ===== rtl/clpw_adv.sv =====
// One all-octant Bresenham move of position and error term.
module clpw_adv
  import clpw_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] x,
  input  logic signed [COORD_BITS-1:0] y,
  input  logic signed [COORD_BITS+2:0] err,
  input  logic        [COORD_BITS:0]   dx,
  input  logic        [COORD_BITS:0]   dy,
  input  logic                         sxn,
  input  logic                         syn,
  output logic signed [COORD_BITS-1:0] x_n,
  output logic signed [COORD_BITS-1:0] y_n,
  output logic signed [COORD_BITS+2:0] err_n
);

  localparam int EW = COORD_BITS + 3;
  localparam int DW = COORD_BITS + 1;

  logic signed [EW:0]   e2;
  logic signed [EW:0]   dx_w;
  logic signed [EW:0]   dy_w;
  logic signed [EW-1:0] dx_e;
  logic signed [EW-1:0] dy_e;
  logic                 mv_x;
  logic                 mv_y;

  always_comb begin
    e2    = {err, 1'b0};
    dx_w  = $signed({{(EW + 1 - DW){1'b0}}, dx});
    dy_w  = $signed({{(EW + 1 - DW){1'b0}}, dy});
    dx_e  = $signed({{(EW - DW){1'b0}}, dx});
    dy_e  = $signed({{(EW - DW){1'b0}}, dy});
    mv_x  = e2 > -dy_w;
    mv_y  = e2 < dx_w;
    err_n = err - (mv_x ? dy_e : '0) + (mv_y ? dx_e : '0);
    x_n   = mv_x ? (sxn ? x - 1'b1 : x + 1'b1) : x;
    y_n   = mv_y ? (syn ? y - 1'b1 : y + 1'b1) : y;
  end

endmodule

// ===== rtl/clpw_addr.sv =====
// Window test and framebuffer byte offset of one pixel.
module clpw_addr
  import clpw_pkg::*;
#(
  parameter int CMP_W = COORD_BITS_DEF + 1
) (
  input  logic signed [CMP_W-1:0]   px,
  input  logic signed [CMP_W-1:0]   py,
  input  clpw_cfg_t                 cfg,
  output logic                      in_win,
  output logic        [OFFSET_W-1:0] offset
);

  localparam int XP_W = WIN_COORD_W + BPP_W;
  localparam int YP_W = WIN_COORD_W + STRIDE_W;

  logic signed [CMP_W-1:0] left_s;
  logic signed [CMP_W-1:0] width_s;
  logic signed [CMP_W-1:0] height_s;
  logic [XP_W-1:0]         x_prod;
  logic [YP_W-1:0]         y_prod;

  always_comb begin
    left_s   = $signed({{(CMP_W - LEFT_W){1'b0}}, cfg.window_left});
    width_s  = $signed({{(CMP_W - WIDTH_W){1'b0}}, cfg.window_width});
    height_s = $signed({{(CMP_W - HEIGHT_W){1'b0}}, cfg.window_height});
    in_win   = (px >= left_s) && (px < width_s) && (py >= 0) && (py < height_s);
    // Inside the window both coordinates are nonnegative and below 2^13.
    x_prod   = XP_W'(px[WIN_COORD_W-1:0]) * XP_W'(cfg.pixel_depth);
    y_prod   = YP_W'(py[WIN_COORD_W-1:0]) * YP_W'(cfg.line_stride);
    offset   = in_win ? (OFFSET_W'(x_prod >> 3) + OFFSET_W'(y_prod)) : '0;
  end

endmodule

// ===== rtl/clipped_line_pixel_walker.sv =====
// Bresenham line walker: accepts one load or step item per clock unless stalled,
// and returns one registered pixel result for each. The rate is set by the loop
// through the state registers, which hold the position one move ahead of the pixel
// last given, so each item needs a single error-term move plus the window test and
// one multiply-add for the byte offset. A load gives the start pixel, each step
// the next one; the end point is never given. Configuration is a write port always
// ready; no memories, so no clearing pass after reset.
module clipped_line_pixel_walker
  import clpw_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_operation,
  input  logic signed [IO_COORD_W-1:0] in_start_x,
  input  logic signed [IO_COORD_W-1:0] in_start_y,
  input  logic signed [IO_COORD_W-1:0] in_end_x,
  input  logic signed [IO_COORD_W-1:0] in_end_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_pixel_valid,
  output logic signed [IO_COORD_W-1:0] out_pixel_x,
  output logic signed [IO_COORD_W-1:0] out_pixel_y,
  output logic                         out_in_window,
  output logic        [OFFSET_W-1:0]   out_byte_offset,
  output logic                         out_last_pixel,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data
);

`include "clipped_line_pixel_walker_assert.svh"

  localparam int CB    = COORD_BITS;
  localparam int DW    = CB + 1;
  localparam int EW    = CB + 3;
  localparam int CMP_W = ((CB > WIN_COORD_W) ? CB : WIN_COORD_W) + 1;

  function automatic logic [CB-1:0] to_coord(input logic [IO_COORD_W-1:0] v);
    logic [CB-1:0] r;
    for (int i = 0; i < CB; i++) r[i] = (i < IO_COORD_W) ? v[i % IO_COORD_W] : 1'b0;
    return r;
  endfunction

  function automatic logic [IO_COORD_W-1:0] to_port(input logic [CB-1:0] c);
    logic [IO_COORD_W-1:0] r;
    for (int i = 0; i < IO_COORD_W; i++) r[i] = (i < CB) ? c[i % CB] : 1'b0;
    return r;
  endfunction

  clpw_cfg_t cfg_r;

  // Line state; the position registers run one move ahead of the last pixel.
  logic signed [CB-1:0] adv_x_r, adv_y_r, tgt_x_r, tgt_y_r;
  logic signed [EW-1:0] adv_err_r;
  logic        [DW-1:0] dx_r, dy_r;
  logic                 sxn_r, syn_r, active_r;
  logic                 active_nxt;

  logic                  out_valid_r, out_pix_r, out_win_r, out_last_r;
  logic [IO_COORD_W-1:0] out_x_r, out_y_r;
  logic [OFFSET_W-1:0]   out_off_r;
  logic                  out_blank;

  logic                 in_acc, is_load;
  logic signed [CB-1:0] sx, sy, ex, ey;
  logic signed [DW-1:0] diff_x, diff_y;
  logic        [DW-1:0] ld_dx, ld_dy;
  logic signed [EW-1:0] ld_err;
  logic signed [CB-1:0] base_x, base_y, sel_tx, sel_ty, n_x, n_y;
  logic signed [EW-1:0] base_err, n_err;
  logic        [DW-1:0] sel_dx, sel_dy;
  logic                 sel_sxn, sel_syn;
  logic                 pix_valid, pix_last, at_tgt;
  logic                 win;
  logic [OFFSET_W-1:0]  off;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    is_load = in_operation == OP_LOAD;
    sx      = $signed(to_coord(in_start_x));
    sy      = $signed(to_coord(in_start_y));
    ex      = $signed(to_coord(in_end_x));
    ey      = $signed(to_coord(in_end_y));
    diff_x  = $signed({ex[CB-1], ex}) - $signed({sx[CB-1], sx});
    diff_y  = $signed({ey[CB-1], ey}) - $signed({sy[CB-1], sy});
    ld_dx   = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
    ld_dy   = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
    ld_err  = $signed({{(EW - DW){1'b0}}, ld_dx}) - $signed({{(EW - DW){1'b0}}, ld_dy});

    base_x   = is_load ? sx : adv_x_r;
    base_y   = is_load ? sy : adv_y_r;
    base_err = is_load ? ld_err : adv_err_r;
    sel_tx   = is_load ? ex : tgt_x_r;
    sel_ty   = is_load ? ey : tgt_y_r;
    sel_dx   = is_load ? ld_dx : dx_r;
    sel_dy   = is_load ? ld_dy : dy_r;
    sel_sxn  = is_load ? !(sx < ex) : sxn_r;
    sel_syn  = is_load ? !(sy < ey) : syn_r;

    // A step with no line, or any item whose position is already the end point, gives no pixel.
    at_tgt     = (base_x == sel_tx) && (base_y == sel_ty);
    pix_valid  = (is_load || active_r) && !at_tgt;
    pix_last   = pix_valid && (n_x == sel_tx) && (n_y == sel_ty);
    active_nxt = pix_valid && !pix_last;
  end

  clpw_adv #(
    .COORD_BITS(CB)
  ) u_adv (
    .x    (base_x),
    .y    (base_y),
    .err  (base_err),
    .dx   (sel_dx),
    .dy   (sel_dy),
    .sxn  (sel_sxn),
    .syn  (sel_syn),
    .x_n  (n_x),
    .y_n  (n_y),
    .err_n(n_err)
  );

  clpw_addr #(
    .CMP_W(CMP_W)
  ) u_addr (
    .px    ($signed({{(CMP_W - CB){base_x[CB-1]}}, base_x})),
    .py    ($signed({{(CMP_W - CB){base_y[CB-1]}}, base_y})),
    .cfg   (cfg_r),
    .in_win(win),
    .offset(off)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_left   <= RST_WINDOW_LEFT;
      cfg_r.window_width  <= RST_WINDOW_WIDTH;
      cfg_r.window_height <= RST_WINDOW_HEIGHT;
      cfg_r.pixel_depth   <= RST_PIXEL_DEPTH;
      cfg_r.line_stride   <= RST_LINE_STRIDE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WINDOW_LEFT:   cfg_r.window_left   <= cfg_data[LEFT_W-1:0];
        CFG_WINDOW_WIDTH:  cfg_r.window_width  <= cfg_data[WIDTH_W-1:0];
        CFG_WINDOW_HEIGHT: cfg_r.window_height <= cfg_data[HEIGHT_W-1:0];
        CFG_PIXEL_DEPTH:   cfg_r.pixel_depth   <= cfg_data[BPP_W-1:0];
        CFG_LINE_STRIDE:   cfg_r.line_stride   <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) active_r <= active_nxt;
      if (in_acc) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (is_load) begin
        tgt_x_r <= ex;
        tgt_y_r <= ey;
        dx_r    <= ld_dx;
        dy_r    <= ld_dy;
        sxn_r   <= sel_sxn;
        syn_r   <= sel_syn;
      end
      // Advance only when a pixel goes out; an idle step leaves the line alone.
      if (pix_valid) begin
        adv_x_r   <= n_x;
        adv_y_r   <= n_y;
        adv_err_r <= n_err;
      end
      out_pix_r  <= pix_valid;
      out_x_r    <= pix_valid ? to_port(base_x) : '0;
      out_y_r    <= pix_valid ? to_port(base_y) : '0;
      out_win_r  <= pix_valid && win;
      out_off_r  <= pix_valid ? off : '0;
      out_last_r <= pix_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_valid = out_pix_r;
  assign out_pixel_x     = $signed(out_x_r);
  assign out_pixel_y     = $signed(out_y_r);
  assign out_in_window   = out_win_r;
  assign out_byte_offset = out_off_r;
  assign out_last_pixel  = out_last_r;

  assign out_blank = out_x_r == '0 && out_y_r == '0 && !out_win_r && out_off_r == '0 &&
                     !out_last_r;

  `CLPW_ASSERT(a_empty_zero, out_valid_r && !out_pix_r |-> out_blank, "empty result not blank")
  `CLPW_ASSERT(a_clip_zero, out_valid_r && !out_win_r |-> out_off_r == '0, "offset off window")
  `CLPW_ASSERT(a_last_pix, out_valid_r && out_last_r |-> out_pix_r && !active_r, "stray last")
  `CLPW_ASSERT(a_idle, in_acc && !is_load && !active_r |=> !out_pix_r, "idle step gave a pixel")

endmodule

// ===== tb/sv/tb_clipped_line_pixel_walker.sv =====
// Self-checking testbench for the clipped Bresenham line pixel walker.
`timescale 1ns / 100ps

module tb_clipped_line_pixel_walker
  import clpw_pkg::*;
();

  localparam int QUIET_LIMIT = 2000;

  typedef logic signed [IO_COORD_W-1:0] coord_t;

  typedef struct packed {
    logic                valid;
    coord_t              x;
    coord_t              y;
    logic                in_win;
    logic [OFFSET_W-1:0] offset;
    logic                last;
  } pixel_t;

  typedef struct {
    logic   op;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    bit     fixed;
    pixel_t want;
  } drive_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_operation = OP_LOAD;
  coord_t                in_start_x = '0;
  coord_t                in_start_y = '0;
  coord_t                in_end_x = '0;
  coord_t                in_end_y = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_pixel_valid;
  coord_t                out_pixel_x;
  coord_t                out_pixel_y;
  logic                  out_in_window;
  logic [OFFSET_W-1:0]   out_byte_offset;
  logic                  out_last_pixel;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_WINDOW_LEFT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Window and framebuffer settings as the block should hold them.
  logic [LEFT_W-1:0]   win_left   = RST_WINDOW_LEFT;
  logic [WIDTH_W-1:0]  win_width  = RST_WINDOW_WIDTH;
  logic [HEIGHT_W-1:0] win_height = RST_WINDOW_HEIGHT;
  logic [BPP_W-1:0]    pix_bits   = RST_PIXEL_DEPTH;
  logic [STRIDE_W-1:0] row_stride = RST_LINE_STRIDE;

  // Line walk state.
  coord_t             pos_x = '0;
  coord_t             pos_y = '0;
  coord_t             goal_x = '0;
  coord_t             goal_y = '0;
  logic [16:0]        span_x = '0;
  logic [16:0]        span_y = '0;
  logic               x_back = 1'b0;
  logic               y_back = 1'b0;
  logic signed [18:0] err_acc = '0;
  logic               drawing = 1'b0;

  pixel_t     pending_pixels[$];
  drive_row_t drive_rows[$];
  int         errors = 0;
  int         quiet_cycles = 0;
  int         in_gap_pct = 0;
  int         out_stall_pct = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  clipped_line_pixel_walker u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_valid (out_pixel_valid),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_in_window   (out_in_window),
    .out_byte_offset (out_byte_offset),
    .out_last_pixel  (out_last_pixel),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  // One move of the all-octant error walk.
  function automatic void bres_move(inout coord_t x, inout coord_t y,
                                    inout logic signed [18:0] err);
    int e2;
    e2 = 2 * int'(err);
    if (e2 > -int'(span_y)) begin
      err = 19'(int'(err) - int'(span_y));
      x = x_back ? x - 16'sd1 : x + 16'sd1;
    end
    if (e2 < int'(span_x)) begin
      err = 19'(int'(err) + int'(span_x));
      y = y_back ? y - 16'sd1 : y + 16'sd1;
    end
  endfunction

  function automatic pixel_t emit_pixel();
    pixel_t             p;
    coord_t             nx;
    coord_t             ny;
    logic signed [18:0] ne;
    longint             off;
    nx = pos_x;
    ny = pos_y;
    ne = err_acc;
    // Peek one move ahead: the end point itself is never drawn.
    bres_move(nx, ny, ne);
    p = '0;
    p.valid = 1'b1;
    p.x = pos_x;
    p.y = pos_y;
    p.last = (nx == goal_x) && (ny == goal_y);
    p.in_win = int'(pos_x) >= int'(win_left) && int'(pos_x) < int'(win_width) &&
               int'(pos_y) >= 0 && int'(pos_y) < int'(win_height);
    if (p.in_win) begin
      off = ((longint'(pos_x) * longint'(pix_bits)) >>> 3) +
            longint'(pos_y) * longint'(row_stride);
      p.offset = off[31:0];
    end
    if (p.last) drawing = 1'b0;
    return p;
  endfunction

  function automatic pixel_t predict_pixel(input logic op, input coord_t sx, input coord_t sy,
                                           input coord_t ex, input coord_t ey);
    int ddx;
    int ddy;
    if (op == OP_LOAD) begin
      ddx = int'(ex) - int'(sx);
      ddy = int'(ey) - int'(sy);
      pos_x = sx;
      pos_y = sy;
      goal_x = ex;
      goal_y = ey;
      span_x = 17'(ddx < 0 ? -ddx : ddx);
      span_y = 17'(ddy < 0 ? -ddy : ddy);
      x_back = !(sx < ex);
      y_back = !(sy < ey);
      err_acc = 19'(int'(span_x) - int'(span_y));
      if (ddx == 0 && ddy == 0) begin
        drawing = 1'b0;
        return '0;
      end
      drawing = 1'b1;
      return emit_pixel();
    end
    if (!drawing) return '0;
    bres_move(pos_x, pos_y, err_acc);
    if (pos_x == goal_x && pos_y == goal_y) begin
      drawing = 1'b0;
      return '0;
    end
    return emit_pixel();
  endfunction

  function automatic coord_t clamp_coord(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return coord_t'(v);
  endfunction

  // Bias coordinates toward the window edges and the extremes of the range.
  function automatic coord_t pick_coord(input bit horiz);
    int extent;
    int base;
    extent = horiz ? int'(win_width) : int'(win_height);
    base = horiz ? int'(win_left) : 0;
    case ($urandom_range(0, 9))
      0: return coord_t'($urandom);
      1: return coord_t'(32767 - int'($urandom_range(0, 24)));
      2: return coord_t'(-32768 + int'($urandom_range(0, 24)));
      3: return coord_t'(base + int'($urandom_range(0, 24)) - 12);
      4: return coord_t'(extent + int'($urandom_range(0, 24)) - 12);
      default: return coord_t'(int'($urandom_range(0, extent + 24)) - 12);
    endcase
  endfunction

  task automatic add_row(input logic op, input int sx, sy, ex, ey, input bit fixed,
                         input logic pv, input int px, py, input logic pw,
                         input longint po, input logic pl);
    drive_row_t r;
    r.op = op;
    r.sx = coord_t'(sx);
    r.sy = coord_t'(sy);
    r.ex = coord_t'(ex);
    r.ey = coord_t'(ey);
    r.fixed = fixed;
    r.want = '0;
    r.want.valid = pv;
    r.want.x = coord_t'(px);
    r.want.y = coord_t'(py);
    r.want.in_win = pw;
    r.want.offset = po[31:0];
    r.want.last = pl;
    drive_rows.push_back(r);
  endtask

  task automatic send_item(input logic op, input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey,
                           input bit fixed, input pixel_t want);
    pixel_t predicted;
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x <= ex;
    in_end_y <= ey;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_pixel(op, sx, sy, ex, ey);
    pending_pixels.push_back(fixed ? want : predicted);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_WINDOW_LEFT:   win_left = data[LEFT_W-1:0];
      CFG_WINDOW_WIDTH:  win_width = data[WIDTH_W-1:0];
      CFG_WINDOW_HEIGHT: win_height = data[HEIGHT_W-1:0];
      CFG_PIXEL_DEPTH:   pix_bits = data[BPP_W-1:0];
      CFG_LINE_STRIDE:   row_stride = data[STRIDE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_window(input int left_col, width_cols, height_rows, bits,
                                stride_bytes);
    write_reg(CFG_WINDOW_LEFT, 16'(left_col));
    write_reg(CFG_WINDOW_WIDTH, 16'(width_cols));
    write_reg(CFG_WINDOW_HEIGHT, 16'(height_rows));
    write_reg(CFG_PIXEL_DEPTH, 16'(bits));
    write_reg(CFG_LINE_STRIDE, 16'(stride_bytes));
    cfg_valid <= 1'b0;
  endtask

  // Mostly a load followed by enough steps to run the line out; some noise.
  task automatic random_lines(input int quota);
    int     sent;
    int     len;
    int     steps;
    int     k;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(1'($urandom_range(0, 1)), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom), 1'b0, '0);
        sent++;
      end else begin
        sx = pick_coord(1'b1);
        sy = pick_coord(1'b0);
        k = $urandom_range(0, 19);
        if (k == 0) begin
          ex = sx;
          ey = sy;
        end else if (k < 3) begin
          ex = coord_t'($urandom);
          ey = coord_t'($urandom);
        end else begin
          ex = clamp_coord(int'(sx) + int'($urandom_range(0, 48)) - 24);
          ey = clamp_coord(int'(sy) + int'($urandom_range(0, 48)) - 24);
        end
        send_item(OP_LOAD, sx, sy, ex, ey, 1'b0, '0);
        sent++;
        len = int'(ex) - int'(sx);
        if (len < 0) len = -len;
        k = int'(ey) - int'(sy);
        if (k < 0) k = -k;
        if (k > len) len = k;
        // Cut some lines short; run others past the end.
        steps = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, len))
                                            : len + int'($urandom_range(0, 2));
        if (steps > 40) steps = 40;
        repeat (steps) begin
          send_item(OP_STEP, coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom), coord_t'($urandom), 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= out_stall_pct);

  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel_valid !== want.valid)
          report_mismatch($sformatf("pixel_valid got %0b want %0b",
                                    out_pixel_valid, want.valid));
        if (out_pixel_x !== want.x)
          report_mismatch($sformatf("pixel_x got %0d want %0d", out_pixel_x, want.x));
        if (out_pixel_y !== want.y)
          report_mismatch($sformatf("pixel_y got %0d want %0d", out_pixel_y, want.y));
        if (out_in_window !== want.in_win)
          report_mismatch($sformatf("in_window got %0b want %0b",
                                    out_in_window, want.in_win));
        if (out_byte_offset !== want.offset)
          report_mismatch($sformatf("byte_offset got %0h want %0h",
                                    out_byte_offset, want.offset));
        if (out_last_pixel !== want.last)
          report_mismatch($sformatf("last_pixel got %0b want %0b",
                                    out_last_pixel, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : run
    int p;
    // Rows with typed results follow from reset settings: window 1024x768, 32 bpp.
    add_row(OP_STEP, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(OP_LOAD, 3, 2, 3, 2, 1, 0, 0, 0, 0, 0, 0);
    add_row(OP_STEP, -1, -1, -1, -1, 1, 0, 0, 0, 0, 0, 0);
    add_row(OP_LOAD, 0, 0, 2, 0, 1, 1, 0, 0, 1, 0, 0);
    add_row(OP_STEP, 0, 0, 0, 0, 1, 1, 1, 0, 1, 4, 1);
    add_row(OP_STEP, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(OP_LOAD, -32768, -32768, 32767, 32767, 1, 1, -32768, -32768, 0, 0, 0);
    add_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_LOAD, 32767, 32767, -32768, -32768, 1, 1, 32767, 32767, 0, 0, 0);
    add_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_LOAD, 1023, 767, 1024, 767, 1, 1, 1023, 767, 1, 3145724, 1);
    add_row(OP_STEP, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(OP_LOAD, 1024, 0, 1024, 5, 1, 1, 1024, 0, 0, 0, 0);
    add_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_LOAD, 0, -1, -5, 3, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_LOAD, 0, 768, 0, 767, 1, 1, 0, 768, 0, 0, 1);
    add_row(OP_LOAD, -1, 0, 4, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_LOAD, 5, 7, -32768, 32767, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (drive_rows[i])
      send_item(drive_rows[i].op, drive_rows[i].sx, drive_rows[i].sy,
                drive_rows[i].ex, drive_rows[i].ey, drive_rows[i].fixed, drive_rows[i].want);
    random_lines(150);

    for (p = 0; p < 8; p++) begin
      // Drain before touching the settings.
      in_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clk);
      case (p)
        0: program_window(0, 4096, 4096, 8, 1);
        1: program_window(4095, 4096, 1, 32, 65535);
        2: program_window(0, 0, 0, 0, 0);
        3: program_window(200, 100, 768, 24, 3000);
        4: program_window(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        5: program_window(16, 640, 480, 17, 1280);
        default: program_window($urandom_range(0, 300), $urandom_range(1, 4096),
                                $urandom_range(1, 4096), $urandom_range(0, 63),
                                $urandom_range(0, 65535));
      endcase
      case (p % 4)
        0: begin in_gap_pct = 0;  out_stall_pct = 0;  end
        1: begin in_gap_pct = 60; out_stall_pct = 0;  end
        2: begin in_gap_pct = 0;  out_stall_pct = 60; end
        default: begin in_gap_pct = 16; out_stall_pct = 16; end
      endcase
      random_lines(165);
    end

    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
